// ===== hw/rtl/e2c_pkg.sv =====
// Shared types, constants and month-length function for the epoch-to-calendar converter.
package e2c_pkg;

  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned EPOCH_WEEKDAY = 4;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned LEAP_OFS_100  = 69;
  localparam int unsigned LEAP_OFS_400  = 369;
  localparam int unsigned CENTURY       = 100;
  localparam int unsigned QUAD_CENTURY  = 400;
  // only non-leap multiple of four inside the 32-bit epoch range
  localparam int unsigned SKIP_YEAR     = 2100;
  localparam logic [7:0]  SKIP_IDX      = 8'(SKIP_YEAR - EPOCH_YEAR);

  localparam int unsigned DVD_W  = 32;
  localparam int unsigned DVS_W  = 9;
  localparam int unsigned REM_W  = DVS_W + 1;
  localparam int unsigned PROD_W = 2 * DVD_W;

  // floor(2^32 / d): the quotient estimate from one multiply is low by at most one
  localparam logic [PROD_W-1:0] RCP_ONE = PROD_W'(1) << DVD_W;
  localparam logic [DVD_W-1:0] RCP_SECS_PER_MIN  = DVD_W'(RCP_ONE / PROD_W'(SECS_PER_MIN));
  localparam logic [DVD_W-1:0] RCP_MINS_PER_HOUR = DVD_W'(RCP_ONE / PROD_W'(MINS_PER_HOUR));
  localparam logic [DVD_W-1:0] RCP_HOURS_PER_DAY = DVD_W'(RCP_ONE / PROD_W'(HOURS_PER_DAY));
  localparam logic [DVD_W-1:0] RCP_DAYS_PER_WEEK = DVD_W'(RCP_ONE / PROD_W'(DAYS_PER_WEEK));
  localparam logic [DVD_W-1:0] RCP_DAYS_PER_YEAR = DVD_W'(RCP_ONE / PROD_W'(DAYS_PER_YEAR));
  localparam logic [DVD_W-1:0] RCP_CENTURY       = DVD_W'(RCP_ONE / PROD_W'(CENTURY));
  localparam logic [DVD_W-1:0] RCP_QUAD_CENTURY  = DVD_W'(RCP_ONE / PROD_W'(QUAD_CENTURY));

  // request to the shared divider
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [DVD_W-1:0] recip;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    if (mon == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (mon < 4'd8) begin
      len = mon[0] ? 5'd31 : 5'd30;
    end else begin
      len = mon[0] ? 5'd30 : 5'd31;
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/e2c_div.sv =====
// Shared divide-by-constant unit: reciprocal multiply, remainder, one correction step.
module e2c_div (
  input  logic              clk,
  input  logic              rst_n,
  input  e2c_pkg::div_req_t req,
  output e2c_pkg::div_rsp_t rsp
);

  typedef enum logic [1:0] {
    PH_IDLE, PH_MUL, PH_REM, PH_FIX
  } phase_t;

  phase_t                       phase_r;
  logic                         done_r;
  logic [e2c_pkg::DVD_W-1:0]    dvd_r;
  logic [e2c_pkg::DVS_W-1:0]    dvs_r;
  logic [e2c_pkg::DVD_W-1:0]    rcp_r;
  logic [e2c_pkg::DVD_W-1:0]    est_r;
  logic [e2c_pkg::REM_W-1:0]    part_r;
  logic [e2c_pkg::DVD_W-1:0]    quo_r;
  logic [e2c_pkg::DVS_W-1:0]    rem_r;

  logic [e2c_pkg::PROD_W-1:0]   prod;
  logic [e2c_pkg::DVD_W-1:0]    est;
  logic [e2c_pkg::REM_W-1:0]    part_nxt;
  logic                         fix;

  always_comb begin
    prod     = e2c_pkg::PROD_W'(dvd_r) * e2c_pkg::PROD_W'(rcp_r);
    est      = prod[e2c_pkg::PROD_W-1:e2c_pkg::DVD_W];
    // true remainder of the estimate is below twice the divisor, so low bits suffice
    part_nxt = dvd_r[e2c_pkg::REM_W-1:0]
             - (est_r[e2c_pkg::REM_W-1:0] * e2c_pkg::REM_W'(dvs_r));
    fix      = part_r >= e2c_pkg::REM_W'(dvs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          if (req.start) begin
            dvd_r   <= req.dividend;
            dvs_r   <= req.divisor;
            rcp_r   <= req.recip;
            phase_r <= PH_MUL;
          end
        end
        PH_MUL: begin
          est_r   <= est;
          phase_r <= PH_REM;
        end
        PH_REM: begin
          part_r  <= part_nxt;
          phase_r <= PH_FIX;
        end
        PH_FIX: begin
          quo_r   <= est_r + e2c_pkg::DVD_W'(fix);
          rem_r   <= fix ? e2c_pkg::DVS_W'(part_r - e2c_pkg::REM_W'(dvs_r))
                         : part_r[e2c_pkg::DVS_W-1:0];
          done_r  <= 1'b1;
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Top level: epoch seconds to second, minute, hour, weekday, year, month and day.
//
// A conversion is requested by raising start while busy is low. The block then
// runs ten divisions by constants on one shared unit (reciprocal multiply,
// remainder, correction): /60, /60 and /24 for the time of day, /7 for the
// weekday, /365 for the year estimate and /100, /400 for its leap days, then
// /365, /100 and /400 again for the settled year. The day of year is then
// formed, the month is found by stepping through up to 11 month lengths, and the
// result is registered out. out_valid rises and busy drops in the same cycle, so
// the next request can be taken as the result appears; no new conversion is
// accepted while one runs. The result is there for exactly one cycle with
// out_valid high and must be taken then; the receiver cannot stall it.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [2:0]  out_weekday,
  output logic [8:0]  out_year_day,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_month_day
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEC, ST_MIN, ST_HOUR, ST_WDAY, ST_Y1, ST_L1A, ST_L1B,
    ST_Y2, ST_L2A, ST_L2B, ST_YDAY, ST_MON
  } state_t;

  state_t              state_r;
  e2c_pkg::div_req_t   req;
  e2c_pkg::div_rsp_t   rsp;

  logic [5:0]  sec_r;
  logic [5:0]  min_r;
  logic [4:0]  hour_r;
  logic [2:0]  wday_r;
  logic [15:0] days_r;
  logic [7:0]  yi_r;
  logic [1:0]  q100_r;
  logic [5:0]  leaps_r;
  logic [8:0]  yday_r;
  logic [8:0]  mrem_r;
  logic [3:0]  mon_r;
  logic [4:0]  len_r;
  logic        out_valid_r;

  logic [8:0]  yi_inc;
  logic [5:0]  leaps_c;
  logic [16:0] yr_days;
  logic [15:0] yday_full;
  logic        leap;
  logic        step;

  e2c_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    yi_inc    = {1'b0, yi_r} + 9'd1;
    // leap days before year index: (n+1)/4 - (n+69)/100 + (n+369)/400
    leaps_c   = 6'(yi_inc[8:2]) - {4'b0, q100_r} + {5'b0, rsp.quot[0]};
    yr_days   = 17'(yi_r) * 17'(e2c_pkg::DAYS_PER_YEAR);
    yday_full = days_r - yr_days[15:0] - {10'b0, leaps_r};
    leap      = (yi_r[1:0] == 2'd2) && (yi_r != e2c_pkg::SKIP_IDX);
    step      = (mrem_r >= {4'b0, len_r}) && (mon_r < 4'd12);
  end

  // next division is issued in the cycle the previous one completes
  always_comb begin
    req.start    = 1'b0;
    req.dividend = '0;
    req.divisor  = '0;
    req.recip    = '0;
    unique case (state_r)
      ST_IDLE: begin
        req.start    = start;
        req.dividend = in_epoch_seconds;
        req.divisor  = 9'(e2c_pkg::SECS_PER_MIN);
        req.recip    = e2c_pkg::RCP_SECS_PER_MIN;
      end
      ST_SEC: begin
        req.start    = rsp.done;
        req.dividend = rsp.quot;
        req.divisor  = 9'(e2c_pkg::MINS_PER_HOUR);
        req.recip    = e2c_pkg::RCP_MINS_PER_HOUR;
      end
      ST_MIN: begin
        req.start    = rsp.done;
        req.dividend = rsp.quot;
        req.divisor  = 9'(e2c_pkg::HOURS_PER_DAY);
        req.recip    = e2c_pkg::RCP_HOURS_PER_DAY;
      end
      ST_HOUR: begin
        req.start    = rsp.done;
        req.dividend = 32'(rsp.quot[15:0]) + 32'(e2c_pkg::EPOCH_WEEKDAY);
        req.divisor  = 9'(e2c_pkg::DAYS_PER_WEEK);
        req.recip    = e2c_pkg::RCP_DAYS_PER_WEEK;
      end
      ST_WDAY: begin
        req.start    = rsp.done;
        req.dividend = 32'(days_r);
        req.divisor  = 9'(e2c_pkg::DAYS_PER_YEAR);
        req.recip    = e2c_pkg::RCP_DAYS_PER_YEAR;
      end
      ST_Y1, ST_Y2: begin
        req.start    = rsp.done;
        req.dividend = 32'(rsp.quot[7:0]) + 32'(e2c_pkg::LEAP_OFS_100);
        req.divisor  = 9'(e2c_pkg::CENTURY);
        req.recip    = e2c_pkg::RCP_CENTURY;
      end
      ST_L1A, ST_L2A: begin
        req.start    = rsp.done;
        req.dividend = 32'(yi_r) + 32'(e2c_pkg::LEAP_OFS_400);
        req.divisor  = 9'(e2c_pkg::QUAD_CENTURY);
        req.recip    = e2c_pkg::RCP_QUAD_CENTURY;
      end
      ST_L1B: begin
        req.start    = rsp.done;
        req.dividend = 32'(days_r - {10'b0, leaps_c});
        req.divisor  = 9'(e2c_pkg::DAYS_PER_YEAR);
        req.recip    = e2c_pkg::RCP_DAYS_PER_YEAR;
      end
      ST_L2B, ST_YDAY, ST_MON: begin
        req.start    = 1'b0;
      end
      default: begin
        req.start    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) state_r <= ST_SEC;
        end
        ST_SEC: begin
          if (rsp.done) begin
            sec_r   <= rsp.rem[5:0];
            state_r <= ST_MIN;
          end
        end
        ST_MIN: begin
          if (rsp.done) begin
            min_r   <= rsp.rem[5:0];
            state_r <= ST_HOUR;
          end
        end
        ST_HOUR: begin
          if (rsp.done) begin
            hour_r  <= rsp.rem[4:0];
            days_r  <= rsp.quot[15:0];
            state_r <= ST_WDAY;
          end
        end
        ST_WDAY: begin
          if (rsp.done) begin
            wday_r  <= rsp.rem[2:0];
            state_r <= ST_Y1;
          end
        end
        ST_Y1: begin
          if (rsp.done) begin
            yi_r    <= rsp.quot[7:0];
            state_r <= ST_L1A;
          end
        end
        ST_L1A: begin
          if (rsp.done) begin
            q100_r  <= rsp.quot[1:0];
            state_r <= ST_L1B;
          end
        end
        ST_L1B: begin
          if (rsp.done) state_r <= ST_Y2;
        end
        ST_Y2: begin
          if (rsp.done) begin
            yi_r    <= rsp.quot[7:0];
            state_r <= ST_L2A;
          end
        end
        ST_L2A: begin
          if (rsp.done) begin
            q100_r  <= rsp.quot[1:0];
            state_r <= ST_L2B;
          end
        end
        ST_L2B: begin
          if (rsp.done) begin
            leaps_r <= leaps_c;
            state_r <= ST_YDAY;
          end
        end
        ST_YDAY: begin
          yday_r  <= yday_full[8:0];
          mrem_r  <= yday_full[8:0];
          mon_r   <= 4'd1;
          len_r   <= 5'd31;
          state_r <= ST_MON;
        end
        ST_MON: begin
          if (step) begin
            mrem_r <= mrem_r - {4'b0, len_r};
            mon_r  <= mon_r + 4'd1;
            len_r  <= e2c_pkg::month_len(mon_r + 4'd1, leap);
          end else begin
            out_second    <= sec_r;
            out_minute    <= min_r;
            out_hour      <= hour_r;
            out_weekday   <= wday_r;
            out_year_day  <= yday_r;
            out_year      <= 12'(yi_r) + 12'(e2c_pkg::EPOCH_YEAR);
            out_month     <= mon_r;
            out_month_day <= 5'(mrem_r + 9'd1);
            out_valid_r   <= 1'b1;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== tb/tb_epoch_seconds_to_calendar.sv =====
// Self-checking testbench for the epoch-seconds to calendar converter.
module tb_epoch_seconds_to_calendar;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SECS_PER_DAY   = e2c_pkg::SECS_PER_MIN * e2c_pkg::MINS_PER_HOUR
                                           * e2c_pkg::HOURS_PER_DAY;
  localparam int unsigned RANDOM_COUNT   = 1350;
  localparam int unsigned CALM_TAIL      = 150;   // last requests sent back to back
  localparam int unsigned DRAIN_CYCLES   = 250;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [8:0]  year_day;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  month_day;
  } date_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        typed;   // use the typed-in date instead of the predictor
    date_t       want;
  } stim_row_t;

  localparam int N_DIRECTED = 20;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'd0,          1'b1, '{6'd0,  6'd0,  5'd0,  3'd4, 9'd0,   12'd1970, 4'd1,  5'd1}},
    '{32'd59,         1'b1, '{6'd59, 6'd0,  5'd0,  3'd4, 9'd0,   12'd1970, 4'd1,  5'd1}},
    '{32'd60,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 3'd4, 9'd0,   12'd1970, 4'd1,  5'd1}},
    '{32'd86400,      1'b0, '0},
    '{32'd31535999,   1'b1, '{6'd59, 6'd59, 5'd23, 3'd4, 9'd364, 12'd1970, 4'd12, 5'd31}},
    '{32'd31536000,   1'b0, '0},
    '{32'd68169600,   1'b0, '0},   // 1972-02-29
    '{32'd94694399,   1'b0, '0},   // last day of a leap year
    '{32'd951782400,  1'b0, '0},   // 2000-02-29, century leap
    '{32'd978307199,  1'b0, '0},
    '{32'd2147483647, 1'b0, '0},
    '{32'd4102444799, 1'b0, '0},
    '{32'd4107456000, 1'b0, '0},   // 2100-02-28, century non-leap
    '{32'd4107542400, 1'b0, '0},   // 2100-03-01
    '{32'h5555_5555,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'hFFFF_FFFE,  1'b0, '0},
    '{32'hFFFF_FFFF,  1'b1, '{6'd15, 6'd28, 5'd6,  3'd0, 9'd37,  12'd2106, 4'd2,  5'd7}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [2:0]  out_weekday;
  logic [8:0]  out_year_day;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_month_day;

  date_t pending_dates[$];
  int    error_count = 0;
  int    stall_cycles = 0;

  always #6 clk = ~clk;

  epoch_seconds_to_calendar i_dut (
    .clk,
    .rst_n,
    .start,
    .busy,
    .in_epoch_seconds,
    .out_valid,
    .out_second,
    .out_minute,
    .out_hour,
    .out_weekday,
    .out_year_day,
    .out_year,
    .out_month,
    .out_month_day
  );

  // leap days in the n years starting at the epoch year
  function automatic int unsigned leap_days_in(input int unsigned n);
    return ((n + 1) >> 2) - (n + e2c_pkg::LEAP_OFS_100) / e2c_pkg::CENTURY
           + (n + e2c_pkg::LEAP_OFS_400) / e2c_pkg::QUAD_CENTURY;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned yr);
    bit leap;
    leap = ((yr % 4 == 0) && (yr % e2c_pkg::CENTURY != 0)) || (yr % e2c_pkg::QUAD_CENTURY == 0);
    case (mon)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic date_t calendar_of(input logic [31:0] secs);
    date_t       d;
    int unsigned t, days, yi, yday, yr, mon, rest;
    t = secs;
    d.second = 6'(t % e2c_pkg::SECS_PER_MIN);
    t = t / e2c_pkg::SECS_PER_MIN;
    d.minute = 6'(t % e2c_pkg::MINS_PER_HOUR);
    t = t / e2c_pkg::MINS_PER_HOUR;
    d.hour = 5'(t % e2c_pkg::HOURS_PER_DAY);
    days = t / e2c_pkg::HOURS_PER_DAY;
    d.weekday = 3'((days + e2c_pkg::EPOCH_WEEKDAY) % e2c_pkg::DAYS_PER_WEEK);
    // first guess overshoots by the leap days; second pass settles it
    yi = days / e2c_pkg::DAYS_PER_YEAR;
    yi = (days - leap_days_in(yi)) / e2c_pkg::DAYS_PER_YEAR;
    yday = days - (yi * e2c_pkg::DAYS_PER_YEAR + leap_days_in(yi));
    yr = yi + e2c_pkg::EPOCH_YEAR;
    rest = yday;
    mon = 1;
    while (mon < 12 && rest >= days_in_month(mon, yr)) begin
      rest = rest - days_in_month(mon, yr);
      mon++;
    end
    d.year_day = 9'(yday);
    d.year = 12'(yr);
    d.month = 4'(mon);
    d.month_day = 5'(rest + 1);
    return d;
  endfunction

  function automatic logic [31:0] random_epoch();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      5, 6: begin
        // day boundaries: first or last second of a random day
        return $urandom_range(0, 49709) * SECS_PER_DAY + ($urandom_range(0, 1) ? 86399 : 0);
      end
      7:       return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      8:       return $urandom_range(0, 200000);
      9:       return 32'd4107456000 + $urandom_range(0, 3 * SECS_PER_DAY);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_request(input logic [31:0] secs, input logic typed, input date_t want);
    start <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (busy);
    pending_dates.push_back(typed ? want : calendar_of(secs));
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].secs, directed_rows[i].typed, directed_rows[i].want);
      maybe_idle(1'b1);
    end
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      send_request(random_epoch(), 1'b0, '0);
      maybe_idle(n < RANDOM_COUNT - CALM_TAIL);
    end
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_epoch_seconds_to_calendar: clean");
    end else begin
      $display("tb_epoch_seconds_to_calendar: errors");
    end
    $finish;
  end

  // results are taken the cycle they appear
  always @(posedge clk) begin
    date_t want;
    int    got_f[8];
    int    want_f[8];
    string field_names[8];
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding (year %0d)", out_year));
      end else begin
        want = pending_dates.pop_front();
        field_names = '{"second", "minute", "hour", "weekday",
                        "year_day", "year", "month", "month_day"};
        got_f = '{out_second, out_minute, out_hour, out_weekday,
                  out_year_day, out_year, out_month, out_month_day};
        want_f = '{want.second, want.minute, want.hour, want.weekday,
                   want.year_day, want.year, want.month, want.month_day};
        for (int f = 0; f < 8; f++) begin
          if (got_f[f] != want_f[f]) begin
            report_mismatch($sformatf("%s got %0d want %0d", field_names[f], got_f[f],
                                      want_f[f]));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_epoch_seconds_to_calendar: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
